// ===== hw/rtl/tprse_pkg.sv =====
// ----------------------------------------------------------------------------
// tprse_pkg: shared types and constants
// Command format between front and back, back-end states, register indexes.
// ----------------------------------------------------------------------------
package tprse_pkg;

    localparam int MaxWidth = 60;                    // widest row, pixels
    localparam int SegLimit = 58;                    // split point for long runs
    localparam int SkipMax  = 63;                    // skip counter saturates here
    localparam int CntW     = $clog2(MaxWidth + 1);  // counts 0..MaxWidth
    localparam int AddrW    = $clog2(MaxWidth);      // buffer address
    localparam int PixW     = 8;
    localparam int RowW     = 8;
    localparam int ByteW    = 8;
    localparam int CfgIdxW  = 2;
    localparam int QDepth   = 2;                     // command queue depth
    localparam int QAw      = $clog2(QDepth);

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgTransparent = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRowWidth    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgRowCount    = 2'd2;

    localparam logic [PixW-1:0] RstTransparent = 8'd0;
    localparam logic [CntW-1:0] RstRowWidth    = 6'd16;
    localparam logic [RowW-1:0] RstRowCount    = 8'd16;

    localparam logic [ByteW-1:0] MarkerByte = 8'd0;

    // one command per pixel that causes work in the back end
    typedef struct packed {
        logic [PixW-1:0]  pixel;
        logic             store;       // write pixel into buffer
        logic [AddrW-1:0] store_addr;
        logic             flush;       // emit buffered segment before the store
        logic [CntW-1:0]  fl_skip;
        logic [CntW-1:0]  fl_cnt;
        logic             eol;         // emit closing segment and row marker after
        logic [CntW-1:0]  eol_skip;
        logic [CntW-1:0]  eol_cnt;
        logic             done;        // row marker closes the block
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SKIP,
        B_CNT,
        B_PIX,
        B_MARK0,
        B_MARK1
    } back_state_t;

endpackage

// ===== hw/rtl/transparent_run_sprite_encoder.sv =====
// An accepted pixel's command is written into the queue, popped into the command register,
// then its first byte loads the output register; a segment streams one beat per cycle while
// the receiver takes beats. Pixels enter the queue one per cycle while it is not full; a
// command that emits holds the back end until its beats are loaded, so intake can stall.
// Reset: aresetn synchronous, active low; clears counters, queue and registers to
// defaults (transparent 0, width 16, rows 16); the pixel buffer is not cleared.
// ----------------------------------------------------------------------------
// transparent_run_sprite_encoder: top level
// Encodes sprite rows into skip/copy segments with buffered opaque pixels and
// a 0,0 end-of-row marker.
// ----------------------------------------------------------------------------
module transparent_run_sprite_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [tprse_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tprse_pkg::ByteW-1:0]   cfg_wdata,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tprse_pkg::PixW-1:0]    s_pixel,
    // code byte output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tprse_pkg::ByteW-1:0]   m_code_byte,
    output logic                          m_last_of_input,
    output logic                          m_block_done
);

    // front -> queue -> back
    tprse_pkg::cmd_t push_cmd;
    tprse_pkg::cmd_t head_cmd;
    logic            q_push, q_full, q_pop, q_empty;

    // Front: classifies each pixel against the transparent color, tracks
    // the skip/copy runs, column and row, and issues one command per pixel
    // that writes the buffer or produces output.
    tprse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Short queue decouples pixel intake from byte emission.
    tprse_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    // Back: runs each command in order. A flush streams the buffered
    // segment before the new pixel is stored; a row end streams the closing
    // segment and the 0,0 marker.
    tprse_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (head_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_byte     (m_code_byte),
        .m_last_of_input (m_last_of_input),
        .m_block_done    (m_block_done)
    );

endmodule

// ===== hw/rtl/tprse_front.sv =====
// ----------------------------------------------------------------------------
// tprse_front: pixel classifier
// Holds the config registers and run/column/row counters, turns each pixel
// into a command for the back end.
// ----------------------------------------------------------------------------
module tprse_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tprse_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tprse_pkg::ByteW-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tprse_pkg::PixW-1:0]    s_pixel,
    input  logic                          q_full,
    output logic                          q_push,
    output tprse_pkg::cmd_t               q_cmd
);

    logic [tprse_pkg::PixW-1:0] tcolor_reg;
    logic [tprse_pkg::CntW-1:0] width_reg;
    logic [tprse_pkg::RowW-1:0] rows_reg;

    logic [tprse_pkg::CntW-1:0] skip_reg, skip_next;
    logic [tprse_pkg::CntW-1:0] copy_reg, copy_next;
    logic [tprse_pkg::CntW-1:0] column_reg, column_next;
    logic [tprse_pkg::RowW-1:0] row_reg, row_next;

    logic [tprse_pkg::CntW-1:0] w_eff;
    logic [tprse_pkg::RowW-1:0] h_eff;
    logic                       last_col, trans, flush, store, done, accept;
    logic [tprse_pkg::CntW-1:0] skip1, copy1, copy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcolor_reg <= tprse_pkg::RstTransparent;
            width_reg  <= tprse_pkg::RstRowWidth;
            rows_reg   <= tprse_pkg::RstRowCount;
        end else if (cfg_we) begin
            case (cfg_index)
                tprse_pkg::CfgTransparent: tcolor_reg <= cfg_wdata;
                tprse_pkg::CfgRowWidth:    width_reg  <= cfg_wdata[tprse_pkg::CntW-1:0];
                tprse_pkg::CfgRowCount:    rows_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // clamp geometry
        if (width_reg == '0)
            w_eff = tprse_pkg::CntW'(1);
        else if (width_reg > tprse_pkg::CntW'(tprse_pkg::MaxWidth))
            w_eff = tprse_pkg::CntW'(tprse_pkg::MaxWidth);
        else
            w_eff = width_reg;
        h_eff = (rows_reg == '0) ? tprse_pkg::RowW'(1) : rows_reg;

        last_col = ({1'b0, column_reg} + 7'd1) >= {1'b0, w_eff};
        done     = ({1'b0, row_reg} + 9'd1) >= {1'b0, h_eff};
        trans    = (s_pixel == tcolor_reg);

        if (trans)
            flush = (copy_reg != '0);
        else
            flush = (copy_reg >= tprse_pkg::CntW'(tprse_pkg::SegLimit)) && !last_col;

        if (flush)
            skip1 = trans ? tprse_pkg::CntW'(1) : '0;
        else if (trans && (skip_reg < tprse_pkg::CntW'(tprse_pkg::SkipMax)))
            skip1 = skip_reg + tprse_pkg::CntW'(1);
        else
            skip1 = skip_reg;

        copy1 = flush ? '0 : copy_reg;
        store = !trans && (copy1 < tprse_pkg::CntW'(tprse_pkg::MaxWidth));
        copy2 = store ? copy1 + tprse_pkg::CntW'(1) : copy1;

        q_cmd.pixel      = s_pixel;
        q_cmd.store      = store;
        q_cmd.store_addr = copy1[tprse_pkg::AddrW-1:0];
        q_cmd.flush      = flush;
        q_cmd.fl_skip    = skip_reg;
        q_cmd.fl_cnt     = copy_reg;
        q_cmd.eol        = last_col;
        q_cmd.eol_skip   = skip1;
        q_cmd.eol_cnt    = copy2;
        q_cmd.done       = done;

        q_push = accept && (store || flush || last_col);

        skip_next   = skip_reg;
        copy_next   = copy_reg;
        column_next = column_reg;
        row_next    = row_reg;
        if (accept) begin
            if (last_col) begin
                skip_next   = '0;
                copy_next   = '0;
                column_next = '0;
                row_next    = done ? '0 : row_reg + tprse_pkg::RowW'(1);
            end else begin
                skip_next   = skip1;
                copy_next   = copy2;
                column_next = column_reg + tprse_pkg::CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg   <= '0;
            copy_reg   <= '0;
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            skip_reg   <= skip_next;
            copy_reg   <= copy_next;
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== hw/rtl/tprse_fifo.sv =====
// ----------------------------------------------------------------------------
// tprse_fifo: command queue
// Small register FIFO between classifier and byte emitter.
// ----------------------------------------------------------------------------
module tprse_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tprse_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output tprse_pkg::cmd_t pop_data,
    output logic            empty
);

    tprse_pkg::cmd_t               entry_reg [tprse_pkg::QDepth];
    logic [tprse_pkg::QAw-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tprse_pkg::QAw-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tprse_pkg::QAw:0]       count_reg, count_next;
    logic                          do_push, do_pop;

    assign full     = (count_reg == (tprse_pkg::QAw+1)'(tprse_pkg::QDepth));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == tprse_pkg::QAw'(tprse_pkg::QDepth - 1)) ?
                          '0 : wr_ptr_reg + tprse_pkg::QAw'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == tprse_pkg::QAw'(tprse_pkg::QDepth - 1)) ?
                          '0 : rd_ptr_reg + tprse_pkg::QAw'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (tprse_pkg::QAw+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (tprse_pkg::QAw+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/tprse_back.sv =====
// ----------------------------------------------------------------------------
// tprse_back: byte emitter
// Executes commands: segment headers, buffered pixels, row markers.
// Owns the opaque pixel buffer and the output register.
// ----------------------------------------------------------------------------
module tprse_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  tprse_pkg::cmd_t             q_head,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tprse_pkg::ByteW-1:0] m_code_byte,
    output logic                        m_last_of_input,
    output logic                        m_block_done
);

    tprse_pkg::back_state_t      state_reg, state_next;
    tprse_pkg::cmd_t             cmd_reg, cmd_next;
    logic                        phase_reg, phase_next;   // 0: flush segment, 1: row end
    logic [tprse_pkg::CntW-1:0]  idx_reg, idx_next, idx_inc;

    logic [tprse_pkg::PixW-1:0]  opaque_buf_reg [tprse_pkg::MaxWidth];
    logic [tprse_pkg::PixW-1:0]  rd_data_reg;
    logic                        wr_en;
    logic [tprse_pkg::AddrW-1:0] wr_addr;
    logic [tprse_pkg::PixW-1:0]  wr_data;

    logic                        m_valid_reg;
    logic [tprse_pkg::ByteW-1:0] m_code_reg;
    logic                        m_last_reg, m_done_reg;

    logic                        out_free, load, ld_last, ld_done, pix_end;
    logic [tprse_pkg::ByteW-1:0] ld_byte;
    logic [tprse_pkg::CntW-1:0]  seg_skip, seg_cnt;

    assign out_free = !m_valid_reg || m_ready;
    assign seg_skip = phase_reg ? cmd_reg.eol_skip : cmd_reg.fl_skip;
    assign seg_cnt  = phase_reg ? cmd_reg.eol_cnt  : cmd_reg.fl_cnt;
    assign idx_inc  = idx_reg + tprse_pkg::CntW'(1);
    assign pix_end  = (idx_inc == seg_cnt);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tprse_pkg::B_IDLE: begin
                if (!q_empty && (q_head.flush || q_head.eol))
                    state_next = tprse_pkg::B_SKIP;
            end
            tprse_pkg::B_SKIP: begin
                if (out_free)
                    state_next = tprse_pkg::B_CNT;
            end
            tprse_pkg::B_CNT: begin
                if (out_free)
                    state_next = (seg_cnt == '0) ? tprse_pkg::B_MARK0 : tprse_pkg::B_PIX;
            end
            tprse_pkg::B_PIX: begin
                if (out_free && pix_end) begin
                    if (phase_reg)
                        state_next = tprse_pkg::B_MARK0;
                    else if (cmd_reg.eol)
                        state_next = tprse_pkg::B_SKIP;
                    else
                        state_next = tprse_pkg::B_IDLE;
                end
            end
            tprse_pkg::B_MARK0: begin
                if (out_free)
                    state_next = tprse_pkg::B_MARK1;
            end
            tprse_pkg::B_MARK1: begin
                if (out_free)
                    state_next = tprse_pkg::B_IDLE;
            end
            default: state_next = tprse_pkg::B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = q_head.store_addr;
        wr_data    = q_head.pixel;
        load       = 1'b0;
        ld_byte    = tprse_pkg::MarkerByte;
        ld_last    = 1'b0;
        ld_done    = 1'b0;
        case (state_reg)
            tprse_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    phase_next = !q_head.flush;
                    // no flush: store right away
                    wr_en      = !q_head.flush && q_head.store;
                end
            end
            tprse_pkg::B_SKIP: begin
                load    = out_free;
                ld_byte = {2'b00, seg_skip};
            end
            tprse_pkg::B_CNT: begin
                load    = out_free;
                ld_byte = {2'b00, seg_cnt};
                if (out_free)
                    idx_next = '0;
            end
            tprse_pkg::B_PIX: begin
                ld_byte = rd_data_reg;
                if (out_free) begin
                    load     = 1'b1;
                    idx_next = idx_inc;
                    if (pix_end && !phase_reg) begin
                        ld_last    = !cmd_reg.eol;
                        wr_en      = cmd_reg.store;
                        wr_addr    = cmd_reg.store_addr;
                        wr_data    = cmd_reg.pixel;
                        phase_next = 1'b1;
                    end
                end
            end
            tprse_pkg::B_MARK0: begin
                load = out_free;
            end
            tprse_pkg::B_MARK1: begin
                load    = out_free;
                ld_last = 1'b1;
                ld_done = cmd_reg.done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tprse_pkg::B_IDLE;
            phase_reg   <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            if (load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (load) begin
            m_code_reg <= ld_byte;
            m_last_reg <= ld_last;
            m_done_reg <= ld_done;
        end
    end

    // buffer: one write port, one registered read at the upcoming index
    always_ff @(posedge aclk) begin
        if (wr_en)
            opaque_buf_reg[wr_addr] <= wr_data;
        if (idx_next < tprse_pkg::CntW'(tprse_pkg::MaxWidth))
            rd_data_reg <= opaque_buf_reg[idx_next[tprse_pkg::AddrW-1:0]];
    end

    assign m_valid         = m_valid_reg;
    assign m_code_byte     = m_code_reg;
    assign m_last_of_input = m_last_reg;
    assign m_block_done    = m_done_reg;

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_last_reg)
        else $error("block end flag without last flag");

    a_pix_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tprse_pkg::B_PIX) |-> (seg_cnt != '0) && (idx_reg < seg_cnt))
        else $error("pixel index outside segment");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tprse_pkg::B_MARK1 && out_free) |=> (m_valid_reg && m_last_reg))
        else $error("row marker not flagged last");
`endif

endmodule

// ===== verif/transparent_run_sprite_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// transparent_run_sprite_encoder_tb: self-checking testbench
// Drives pixel beats and register writes into the encoder, mirrors the run
// encoding in a behavioral predictor, and checks every code byte beat with its
// flags against the expected stream. Both handshakes idle at random, and the
// receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module transparent_run_sprite_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkHalf      = 5;      // 10 ns period
    localparam int ResetCycles  = 12;
    localparam int IdlePct      = 34;     // idle cycles per hundred, each side
    localparam int SettleCycles = 8;      // pipeline depth margin after the last beat
    localparam int HoldCycles   = 300;    // long receiver hold-off
    localparam int StallLimit   = 3000;   // watchdog: cycles with no beat on either side
    localparam int MaxReports   = 10;
    localparam int ItemTarget   = 270;    // pixel beats over the whole run

    // index 3 decodes to no register
    localparam logic [tprse_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

    typedef struct packed {
        logic [tprse_pkg::ByteW-1:0] code;
        logic                        last;
        logic                        done;
    } code_beat_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [tprse_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [tprse_pkg::ByteW-1:0]   cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [tprse_pkg::PixW-1:0]    s_pixel   = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [tprse_pkg::ByteW-1:0]   m_code_byte;
    logic                          m_last_of_input;
    logic                          m_block_done;

    transparent_run_sprite_encoder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_byte     (m_code_byte),
        .m_last_of_input (m_last_of_input),
        .m_block_done    (m_block_done)
    );

    initial begin
        forever #ClkHalf aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Encoder mirror: register copies and run state, updated from the
    // beats and writes seen on the ports.
    // ------------------------------------------------------------------
    logic [tprse_pkg::PixW-1:0]  enc_trans;
    logic [tprse_pkg::CntW-1:0]  enc_width;
    logic [tprse_pkg::RowW-1:0]  enc_rows;
    int unsigned                 enc_skip;
    int unsigned                 enc_copy;
    logic [tprse_pkg::PixW-1:0]  enc_buf [tprse_pkg::MaxWidth];
    logic [tprse_pkg::CntW-1:0]  enc_col;
    logic [tprse_pkg::RowW-1:0]  enc_row;

    code_beat_t expected_codes[$];    // code beats still owed by the block
    code_beat_t step_codes[$];        // beats caused by the pixel being encoded

    int mismatch_count = 0;

    // testbench-side knobs
    logic [tprse_pkg::PixW-1:0] cur_trans     = tprse_pkg::RstTransparent;
    logic                       steady_run    = 1'b0;  // no idling on either side
    int                         hold_requests = 0;
    int                         holds_done    = 0;
    int unsigned                items_sent    = 0;
    int unsigned                run_left      = 0;
    bit                         run_opaque    = 1'b0;

    function automatic void emit_code(input logic [tprse_pkg::ByteW-1:0] b);
        step_codes.push_back(code_beat_t'{b, 1'b0, 1'b0});
    endfunction

    // skip byte, copy byte, then the buffered opaque pixels
    function automatic void emit_segment();
        int unsigned n;
        n = (enc_copy > tprse_pkg::MaxWidth) ? tprse_pkg::MaxWidth : enc_copy;
        emit_code(8'(enc_skip));
        emit_code(8'(n));
        for (int unsigned i = 0; i < n; i++)
            emit_code(enc_buf[i]);
    endfunction

    function automatic void encode_pixel(input logic [tprse_pkg::PixW-1:0] px);
        int unsigned w;
        int unsigned h;
        int          idx;
        bit          at_row_end;
        bit          blk_end;
        w = enc_width;
        if (w == 0)
            w = 1;
        if (w > tprse_pkg::MaxWidth)
            w = tprse_pkg::MaxWidth;
        h = enc_rows;
        if (h == 0)
            h = 1;
        at_row_end = (int'(enc_col) + 1 >= int'(w));
        step_codes = {};

        if (px == enc_trans) begin
            // transparent pixel closes any pending opaque run
            if (enc_copy != 0) begin
                emit_segment();
                enc_skip = 1;
                enc_copy = 0;
            end else if (enc_skip < tprse_pkg::SkipMax) begin
                enc_skip++;
            end
        end else begin
            // long opaque run: split before the buffer overflows the limit
            if (enc_copy >= tprse_pkg::SegLimit && !at_row_end) begin
                emit_segment();
                enc_skip = 0;
                enc_copy = 0;
            end
            if (enc_copy < tprse_pkg::MaxWidth) begin
                enc_buf[enc_copy] = px;
                enc_copy++;
            end
        end

        if (at_row_end) begin
            blk_end = (int'(enc_row) + 1 >= int'(h));
            if (enc_copy != 0) begin
                emit_segment();
            end else begin
                // trailing transparent run still gets a (skip, 0) segment
                emit_code(8'(enc_skip));
                emit_code('0);
            end
            emit_code(tprse_pkg::MarkerByte);
            emit_code(tprse_pkg::MarkerByte);
            if (blk_end)
                step_codes[step_codes.size() - 1].done = 1'b1;
            enc_skip = 0;
            enc_copy = 0;
            enc_col  = '0;
            enc_row  = blk_end ? '0 : enc_row + 1'b1;
        end else begin
            enc_col = enc_col + 1'b1;
        end

        idx = step_codes.size() - 1;
        if (idx >= 0)
            step_codes[idx].last = 1'b1;
        foreach (step_codes[i])
            expected_codes.push_back(step_codes[i]);
    endfunction

    function automatic void report_mismatch(input string what, input code_beat_t want,
                                            input code_beat_t got);
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
            $display("%0t mismatch (%s): expected code=%02h last=%0b done=%0b",
                     $realtime, what, want.code, want.last, want.done);
            $display("    got code=%02h last=%0b done=%0b", got.code, got.last, got.done);
        end
    endfunction

    // ------------------------------------------------------------------
    // Port monitor: checks output beats first, then applies register
    // writes, then encodes the accepted pixel. All values sampled at the
    // edge, before any nonblocking update of this step lands.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        code_beat_t got;
        code_beat_t want;
        if (!aresetn) begin
            enc_trans = tprse_pkg::RstTransparent;
            enc_width = tprse_pkg::RstRowWidth;
            enc_rows  = tprse_pkg::RstRowCount;
            enc_skip  = 0;
            enc_copy  = 0;
            enc_col   = '0;
            enc_row   = '0;
            expected_codes.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = code_beat_t'{m_code_byte, m_last_of_input, m_block_done};
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected beat", '0, got);
                end else begin
                    want = expected_codes.pop_front();
                    if (got.code !== want.code || got.last !== want.last ||
                        got.done !== want.done)
                        report_mismatch("field", want, got);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    tprse_pkg::CfgTransparent: enc_trans = cfg_wdata;
                    tprse_pkg::CfgRowWidth:    enc_width = cfg_wdata[tprse_pkg::CntW-1:0];
                    tprse_pkg::CfgRowCount:    enc_rows  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                encode_pixel(s_pixel);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, a no-idle mode, and the long
    // hold-off counted here so the sender keeps offering meanwhile.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                holds_done <= holds_done + 1;
            end else begin
                m_ready <= steady_run || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    // watchdog: no beat on either side for too long means a hang
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // one pixel beat; gaps go in before valid rises, never while a pixel waits to be taken
    task automatic send_pixel(input logic [tprse_pkg::PixW-1:0] px);
        if (!steady_run && $urandom_range(0, 99) < IdlePct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IdlePct);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic write_reg(input logic [tprse_pkg::CfgIdxW-1:0] idx,
                             input logic [tprse_pkg::ByteW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == tprse_pkg::CfgTransparent)
            cur_trans = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending, let every owed beat arrive, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_codes.size() != 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    function automatic logic [tprse_pkg::PixW-1:0] opaque_pixel();
        logic [tprse_pkg::PixW-1:0] px;
        do px = 8'($urandom_range(0, 255)); while (px == cur_trans);
        return px;
    endfunction

    // transparent or opaque runs, each kind and length chosen at random, some noise
    task automatic send_runs(input int unsigned count);
        logic [tprse_pkg::PixW-1:0] px;
        for (int unsigned i = 0; i < count; i++) begin
            if (run_left == 0) begin
                run_opaque = 1'($urandom_range(0, 1));
                run_left   = $urandom_range(1, 9);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
                px = 8'($urandom_range(0, 255));
            else if (run_opaque)
                px = opaque_pixel();
            else
                px = cur_trans;
            send_pixel(px);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset registers: transparent 0, 16 wide; first row ends on a
    // transparent run, then four pixels leave a run pending mid-row
    task automatic test_defaults();
        logic [tprse_pkg::PixW-1:0] seq [20];
        seq = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h00, 8'h7F, 8'h55,
                8'hAA, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h33, 8'h00,
                8'h00, 8'h00, 8'hC3, 8'h3C};
        foreach (seq[i])
            send_pixel(seq[i]);
        wait_idle();
    endtask

    // zero width and count while mid-row: every pixel closes a row and a block;
    // then width above the maximum, full count, and a write to no register
    task automatic test_config_extremes();
        write_reg(tprse_pkg::CfgTransparent, 8'hFF);
        write_reg(tprse_pkg::CfgRowWidth, 8'h00);
        write_reg(tprse_pkg::CfgRowCount, 8'h00);
        write_reg(CfgUnused, 8'hA5);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFE);
        send_pixel(8'hFF);
        wait_idle();
        write_reg(tprse_pkg::CfgRowWidth, 8'hFF);   // low six bits 63, clamps to max width
        write_reg(tprse_pkg::CfgRowCount, 8'hFF);
        write_reg(CfgUnused, 8'h00);
    endtask

    // full-width rows: all opaque forces a split segment; leading transparent
    // pixel then 59 opaque fills the buffer past the split point at the row end;
    // the last full-width row runs with no idling on either side
    task automatic test_long_opaque_run();
        write_reg(tprse_pkg::CfgTransparent, 8'($urandom_range(1, 254)));
        write_reg(tprse_pkg::CfgRowCount, 8'd2);
        for (int i = 0; i < tprse_pkg::MaxWidth; i++)
            send_pixel(opaque_pixel());
        send_pixel(cur_trans);
        for (int i = 1; i < tprse_pkg::MaxWidth; i++)
            send_pixel(opaque_pixel());
        wait_idle();
        write_reg(tprse_pkg::CfgRowWidth, 8'(tprse_pkg::MaxWidth));
        steady_run <= 1'b1;
        for (int i = 0; i < tprse_pkg::MaxWidth; i++)
            send_pixel(opaque_pixel());
        wait_idle();
        steady_run <= 1'b0;
    endtask

    // receiver holds off while the sender keeps offering: block must back up
    task automatic test_receiver_hold();
        write_reg(tprse_pkg::CfgTransparent, 8'h5A);
        write_reg(tprse_pkg::CfgRowWidth, 8'd8);
        write_reg(tprse_pkg::CfgRowCount, 8'd4);
        hold_requests <= hold_requests + 1;
        send_runs(32);
        wait_idle();
    endtask

    // random settings per phase, mostly whole blocks; some phases stop
    // part-way so the next settings land mid-row or mid-block
    task automatic test_random_blocks();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned phase;
        phase = 0;
        while (items_sent < ItemTarget) begin
            case ($urandom_range(0, 3))
                0:       write_reg(tprse_pkg::CfgTransparent, 8'h00);
                1:       write_reg(tprse_pkg::CfgTransparent, 8'hFF);
                default: write_reg(tprse_pkg::CfgTransparent, 8'($urandom_range(0, 255)));
            endcase
            w = ($urandom_range(0, 7) == 0) ? tprse_pkg::MaxWidth : $urandom_range(1, 12);
            h = $urandom_range(1, 3);
            write_reg(tprse_pkg::CfgRowWidth, 8'(w));
            write_reg(tprse_pkg::CfgRowCount, 8'(h));
            steady_run <= (phase == 2);    // one whole phase with no idling
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, w * h);
            else
                n = w * h;
            if (n > ItemTarget - items_sent)
                n = ItemTarget - items_sent;
            send_runs(n);
            wait_idle();
            steady_run <= 1'b0;
            phase++;
        end
    endtask

    initial begin
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_config_extremes();
        test_long_opaque_run();
        test_receiver_hold();
        test_random_blocks();
        if (mismatch_count == 0 && expected_codes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
